@@ rtl/integer_to_ascii_digits_top_macros.svh @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top_macros
// Assertion macros used by the RTL top of the ASCII digit converter.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_DIGITS_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITOA_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITOA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and the digit lookup of the ASCII digit converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_CHARS_DEF   = 20;

  localparam int OPCODE_W    = 2;
  localparam int NUMBER_W    = 64;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  // Digit register: enough BCD digits for any value up to 64 bits.
  localparam int NUM_DIGITS = 20;
  localparam int DIG_BITS   = NUM_DIGITS * 4;
  localparam int ND_W       = $clog2(NUM_DIGITS + 1);

  localparam logic [OPCODE_W-1:0] OP_UDEC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SDEC = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_HEX  = 2'd2;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [2:0] CMD_NOP      = 3'd0;
  localparam logic [2:0] CMD_LOAD_DEC = 3'd1;
  localparam logic [2:0] CMD_LOAD_HEX = 3'd2;
  localparam logic [2:0] CMD_DABBLE   = 3'd3;
  localparam logic [2:0] CMD_SHIFT    = 3'd4;

  typedef struct packed {
    logic [2:0]          code;
    logic [NUMBER_W-1:0] value;
  } unit_cmd_t;

  typedef struct packed {
    logic [3:0] top_digit;
    logic       top_zero;
  } unit_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/integer_to_ascii_digits_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top
// Turns one 64-bit value into ASCII text (unsigned, signed or 0x hex),
// most significant character first, last character flagged by tlast.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_*    | in  | tdata: opcode [1:0], number [65:2]
//  out_*   | out | tdata: character [7:0]; tlast: last
//
//  Steps per value: accept, VALUE_WIDTH shift/add-3 steps (decimal only),
//  up to NUM_DIGITS-1 steps to drop leading zero digits plus one to leave,
//  then the characters one by one, each sent while the output register is free.
//  in_tready is high only while no value is in work; the last character may
//  still wait in the output register when the next value is taken.
//  Reset (rst_n low, synchronous) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_digits_top_macros.svh"

module integer_to_ascii_digits_top #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_CHARS   = itoa_pkg::MAX_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [itoa_pkg::IN_TDATA_W-1:0]  in_tdata,   // opcode, number
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [itoa_pkg::OUT_TDATA_W-1:0] out_tdata,  // character
  output logic                             out_tlast
);

  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int OCNT_W = $clog2(MAX_CHARS);
  localparam int ND_W   = itoa_pkg::ND_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ND_W-1:0]   ndig_r, ndig_nxt;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [1:0]        pre_r, pre_nxt;
  logic              hex_r, hex_nxt;
  logic              ovld_r, ovld_nxt;
  logic [7:0]        ochar_r, ochar_nxt;
  logic              olast_r, olast_nxt;

  itoa_pkg::unit_cmd_t  cmd;
  itoa_pkg::unit_stat_t stat;

  logic [itoa_pkg::OPCODE_W-1:0] opcode;
  logic [VALUE_WIDTH-1:0]        val;
  logic [VALUE_WIDTH-1:0]        mag;
  logic                          neg;
  logic                          out_free;
  logic                          emit_last;
  logic                          emit_load;

  assign opcode   = in_tdata[itoa_pkg::OPCODE_W-1:0];
  assign val      = in_tdata[itoa_pkg::OPCODE_W +: VALUE_WIDTH];
  assign neg      = (opcode == itoa_pkg::OP_SDEC) && val[VALUE_WIDTH-1];
  assign mag      = neg ? (~val + 1'b1) : val;
  assign out_free = !ovld_r || out_tready;
  assign emit_last = (ocnt_r == OCNT_W'(MAX_CHARS - 1)) ||
                     ((pre_r == 2'd0) && (ndig_r == ND_W'(1)));
  assign emit_load = (state_r == S_EMIT) && out_free;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ndig_nxt  = ndig_r;
    ocnt_nxt  = ocnt_r;
    pre_nxt   = pre_r;
    hex_nxt   = hex_r;
    ovld_nxt  = ovld_r && !out_tready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    cmd.code  = itoa_pkg::CMD_NOP;
    cmd.value = itoa_pkg::NUMBER_W'(mag);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          hex_nxt  = (opcode == itoa_pkg::OP_HEX);
          pre_nxt  = (opcode == itoa_pkg::OP_HEX) ? 2'd2 : (neg ? 2'd1 : 2'd0);
          cnt_nxt  = CNT_W'(VALUE_WIDTH);
          ndig_nxt = ND_W'(itoa_pkg::NUM_DIGITS);
          ocnt_nxt = '0;
          if (opcode == itoa_pkg::OP_HEX) begin
            cmd.code  = itoa_pkg::CMD_LOAD_HEX;
            state_nxt = S_SKIP;
          end else begin
            cmd.code  = itoa_pkg::CMD_LOAD_DEC;
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        cmd.code = itoa_pkg::CMD_DABBLE;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zero digits, keep at least one
        if (stat.top_zero && (ndig_r != ND_W'(1))) begin
          cmd.code = itoa_pkg::CMD_SHIFT;
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          olast_nxt = emit_last;
          ocnt_nxt  = ocnt_r + 1'b1;
          if (pre_r != 2'd0) begin
            if (hex_r) begin
              ochar_nxt = (pre_r == 2'd2) ? itoa_pkg::CH_ZERO : itoa_pkg::CH_X;
            end else begin
              ochar_nxt = itoa_pkg::CH_MINUS;
            end
            pre_nxt = pre_r - 1'b1;
          end else begin
            ochar_nxt = itoa_pkg::digit_char(stat.top_digit);
            cmd.code  = itoa_pkg::CMD_SHIFT;
            ndig_nxt  = ndig_r - 1'b1;
          end
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    ndig_r  <= ndig_nxt;
    ocnt_r  <= ocnt_nxt;
    pre_r   <= pre_nxt;
    hex_r   <= hex_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  itoa_digit_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_digit_unit (
    .clk  (clk),
    .cmd  (cmd),
    .stat (stat)
  );

  assign out_tvalid = ovld_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

  `ITOA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "accepted a word but stayed ready")
  `ITOA_ASSERT_NOW(a_conv_count, clk, rst_n, state_r == S_CONV, cnt_r != '0, "conversion step counter ran out")
  `ITOA_ASSERT_NOW(a_digits_left, clk, rst_n, state_r == S_EMIT, ndig_r != '0, "emitting with no digit left")
  `ITOA_ASSERT_NEXT(a_idle_after_last, clk, rst_n, emit_load && emit_last, state_r == S_IDLE && out_tlast, "last character did not end the value")

endmodule

@@ rtl/itoa_digit_unit.sv @@
// ----------------------------------------------------------------------------
// itoa_digit_unit
// Shared shift/add-3 unit: builds the BCD digits one input bit per step,
// or holds hex nibbles, and shifts out the top digit on request.
// ----------------------------------------------------------------------------
module itoa_digit_unit #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  itoa_pkg::unit_cmd_t   cmd,
  output itoa_pkg::unit_stat_t  stat
);

  localparam int DB = itoa_pkg::DIG_BITS;

  logic [DB-1:0]          bcd_r, bcd_nxt;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [DB-1:0]          adj;

  // Add 3 to every digit of five or more before the doubling shift.
  always_comb begin
    for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3)
                                                 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    case (cmd.code)
      itoa_pkg::CMD_LOAD_DEC: begin
        bcd_nxt = '0;
        bin_nxt = cmd.value[VALUE_WIDTH-1:0];
      end
      itoa_pkg::CMD_LOAD_HEX: begin
        bcd_nxt = {{(DB-VALUE_WIDTH){1'b0}}, cmd.value[VALUE_WIDTH-1:0]};
      end
      itoa_pkg::CMD_DABBLE: begin
        bcd_nxt = {adj[DB-2:0], bin_r[VALUE_WIDTH-1]};
        bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      end
      itoa_pkg::CMD_SHIFT: begin
        bcd_nxt = {bcd_r[DB-5:0], 4'h0};
      end
      default: begin
        bcd_nxt = bcd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
  end

  assign stat.top_digit = bcd_r[DB-1 -: 4];
  assign stat.top_zero  = (bcd_r[DB-1 -: 4] == 4'h0);

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream test of integer_to_ascii_digits_top. Values go in with opcodes
// (unsigned, signed, hex and the spare code). A scoreboard works out the text
// of each value and checks every character word and its tlast in order.
// Both sides gap and stall at random in some phases and run flat out in
// others.
// ----------------------------------------------------------------------------
module tb;
  import itoa_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int MC = MAX_CHARS_DEF;
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASE_ITEMS  = 50;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  class text_scoreboard;
    text_char_t  expected_chars[$];
    int unsigned errors;
    int unsigned chars_checked;
    int unsigned values_noted;
    int unsigned per_opcode[4];

    function new();
      errors        = 0;
      chars_checked = 0;
      values_noted  = 0;
      foreach (per_opcode[i]) per_opcode[i] = 0;
    endfunction

    function logic [7:0] digit_glyph(input logic [63:0] d);
      return (d < 10) ? CH_ZERO + 8'(d) : CH_UPPER_A + 8'(d - 10);
    endfunction

    // Work out the text of one accepted value and queue its characters.
    function void note_value(input logic [OPCODE_W-1:0] op, input logic [NUMBER_W-1:0] number);
      logic [63:0] mask;
      logic [63:0] mag;
      logic [63:0] base;
      logic [7:0]  text[$];
      logic [7:0]  rev[$];
      int          count;
      text_char_t  ch;
      mask = {64{1'b1}} >> (64 - VW);
      mag  = number & mask;
      base = 64'd10;
      if (op == OP_SDEC) begin
        if (mag[VW-1]) begin
          text.push_back(CH_MINUS);
          mag = (~mag + 64'd1) & mask;
        end
      end else if (op == OP_HEX) begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
        base = 64'd16;
      end
      do begin
        rev.push_back(digit_glyph(mag % base));
        mag = mag / base;
      end while (mag != 0 && rev.size() < 20);
      while (rev.size() != 0) text.push_back(rev.pop_back());
      count = (text.size() < MC) ? text.size() : MC;
      for (int i = 0; i < count; i++) begin
        ch.character = text[i];
        ch.last      = (i == count - 1);
        expected_chars.push_back(ch);
      end
      values_noted++;
      per_opcode[op]++;
    endfunction

    function void check_char(input logic [7:0] character, input logic last);
      text_char_t ch;
      if (expected_chars.size() == 0) begin
        $error("character: no word expected, got %h last %b", character, last);
        errors++;
        return;
      end
      ch = expected_chars.pop_front();
      chars_checked++;
      if (character !== ch.character) begin
        $error("character: expected %h, got %h", ch.character, character);
        errors++;
      end
      if (last !== ch.last) begin
        $error("last: expected %b, got %b", ch.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // opcode [1:0], number [65:2]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // character [7:0]
  logic                   out_tlast;

  text_scoreboard sb;
  bit             tx_gaps;
  bit             rx_stalls;
  int unsigned    idle_cycles;

  integer_to_ascii_digits_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Note accepted values and check accepted character words.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_value(in_tdata[OPCODE_W-1:0], in_tdata[OPCODE_W +: NUMBER_W]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_char(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: in stall phases, after each accepted word, drop tready for a random stretch.
  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        stall = rx_stalls ? $urandom_range(0, 15) : 0;
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_value(input logic [OPCODE_W-1:0] op, input logic [NUMBER_W-1:0] number);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - OPCODE_W - NUMBER_W){1'b0}}, number, op};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [NUMBER_W-1:0] random_number();
    logic [63:0] n;
    logic [63:0] p;
    int          k;
    n = {$urandom(), $urandom()};
    case ($urandom_range(0, 4))
      1: n = n >> $urandom_range(1, 63);
      2: n = ~(n >> $urandom_range(1, 63)) + 64'd1;
      3: begin
        // land on and around a power of ten
        p = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) p = p * 64'd10;
        n = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      4: begin
        if ($urandom_range(0, 1) != 0) n = {1'b1, 63'd0} + 64'($urandom_range(0, 3));
        else n = {64{1'b1}} - 64'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return n;
  endfunction

  initial begin
    logic [OPCODE_W-1:0] op;
    sb        = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_value(OP_UDEC, 64'd0);
    send_value(OP_UDEC, 64'd1);
    send_value(OP_UDEC, 64'd9);
    send_value(OP_UDEC, 64'd10);
    send_value(OP_UDEC, {64{1'b1}});
    send_value(OP_UDEC, 64'd10000000000000000000);
    send_value(OP_UDEC, 64'd9999999999999999999);
    send_value(OP_SDEC, 64'd0);
    send_value(OP_SDEC, 64'd1);
    send_value(OP_SDEC, {64{1'b1}});
    send_value(OP_SDEC, {1'b1, 63'd0});
    send_value(OP_SDEC, {1'b0, {63{1'b1}}});
    send_value(OP_SDEC, -64'sd10);
    send_value(OP_HEX, 64'd0);
    send_value(OP_HEX, 64'hF);
    send_value(OP_HEX, 64'h10);
    send_value(OP_HEX, {64{1'b1}});
    send_value(OP_HEX, 64'h0123_4567_89AB_CDEF);
    send_value(OP_HEX, 64'hFEDC_BA98_7654_3210);
    // spare opcode reads as unsigned decimal
    send_value(OP_SPARE, 64'd0);
    send_value(OP_SPARE, {64{1'b1}});
    send_value(OP_SPARE, 64'd12345);

    // Phases: both sides idle, receiver only, sender only, neither.
    for (int phase = 0; phase < 4; phase++) begin
      tx_gaps   = (phase % 2) == 0;
      rx_stalls = phase < 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = OPCODE_W'($urandom_range(0, 3));
        send_value(op, random_number());
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d values (%0d unsigned, %0d signed, %0d hex, %0d spare opcode)",
             sb.values_noted, sb.per_opcode[OP_UDEC], sb.per_opcode[OP_SDEC],
             sb.per_opcode[OP_HEX], sb.per_opcode[OP_SPARE]);
    $display("summary: %0d character words checked against predicted text",
             sb.chars_checked);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/itoa_pkg.sv
rtl/itoa_digit_unit.sv
rtl/integer_to_ascii_digits_top.sv
dv/tb.sv
